[sv/sdvf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdvf_pkg
// Shared types and constants of the signed-distance variance fusion core.
// ----------------------------------------------------------------------------
package sdvf_pkg;

    localparam int DIST_W   = 16;
    localparam int WEIGHT_W = 9;
    localparam int VAR_W    = 32;
    localparam int GAIN_W   = 17;
    localparam int REM_W    = 33;
    localparam int STEP_W   = 6;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [VAR_W-1:0]  VAR_UNKNOWN = '1;
    localparam logic [GAIN_W-1:0] GAIN_ONE    = 17'h10000;

    // quotient bit counts of the two divisions
    localparam logic [STEP_W-1:0] MEAS_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] GAIN_STEPS = 6'd17;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem_init;
        logic [VAR_W-1:0]  num;
        logic [REM_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAR_W-1:0] quo;
    } div_stat_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_R    = 9'b000000100,
        S_RDIV = 9'b000001000,
        S_KDIV = 9'b000010000,
        S_MK   = 9'b000100000,
        S_VK   = 9'b001000000,
        S_VW   = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

[sv/signed_distance_variance_fusion_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_distance_variance_fusion_core
// Scalar Kalman update of one signed-distance estimate (mean, variance) in
// fixed point, built from a small sequencer, one shared multiplier and one
// shared radix-2 divider.
// ----------------------------------------------------------------------------
//  channel | dir | signals                   | content
//  s_      | in  | tvalid, tready, tdata,    | tuser = op; tdata = distance,
//          |     | tuser                     | weight
//  m_      | out | tvalid, tready, tdata     | mean_out, variance_out, observed
//
//  A set item takes the distance as the mean and its square as the variance.
//  A fuse on an unknown variance waits on the 32-bit division; any later fuse
//  adds the 17-bit gain division, skipped when both variances are zero, and
//  makes three passes through the multiplier in all. A new item is taken
//  only after the last has reached the output register; s_tready is high only
//  in idle. A finished result waits in the output
//  register; the next item is accepted while it waits, and the sequencer holds
//  before writing its own result until that register is free.
//  Reset clears the mean, marks the variance unknown (all ones).
// ----------------------------------------------------------------------------
module signed_distance_variance_fusion_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [15:0] distance, [24:16] weight, rest zero
    input  wire         s_tuser,   // [0] op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata    // [15:0] mean_out, [47:16] variance_out,
                                   // [48] observed, rest zero
);
    import sdvf_pkg::*;

    state_t state_reg;

    logic                       op_reg;
    logic signed [DIST_W-1:0]   dist_reg;
    logic [WEIGHT_W-1:0]        wt_reg;
    logic [DIST_W-1:0]          dabs_reg;
    logic [DIST_W-1:0]          mag_reg;
    logic                       neg_reg;
    logic [GAIN_W-1:0]          k_reg;
    logic [DIST_W-1:0]          mean_reg;
    logic [VAR_W-1:0]           var_reg;
    logic                       m_tvalid_reg;
    logic [55:0]                m_tdata_reg;

    logic                       in_fire;
    logic signed [DIST_W-1:0]   in_dist;
    logic [DIST_W-1:0]          in_dabs;
    logic signed [DIST_W:0]     in_res;
    logic [DIST_W:0]            in_res_neg;
    logic                       out_free;

    logic                       mul_en;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod;

    div_req_t                   dreq;
    div_stat_t                  dstat;

    logic [VAR_W:0]             gain_sum;
    logic [33:0]                step_round;
    logic [17:0]                step;
    logic signed [18:0]         mean_wide;
    logic signed [18:0]         mean_sat_in;
    logic [DIST_W-1:0]          mean_new;

    assign in_fire    = s_tvalid && s_tready;
    assign in_dist    = s_tdata[DIST_W-1:0];
    assign in_dabs    = in_dist[DIST_W-1] ? DIST_W'(~in_dist + 1'b1) : in_dist;
    assign in_res     = {in_dist[DIST_W-1], in_dist} - {mean_reg[DIST_W-1], mean_reg};
    assign in_res_neg = ~in_res + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // gain divisor P + R; R is the quotient just finished
    assign gain_sum   = {1'b0, var_reg} + {1'b0, dstat.quo};

    // mean step: round |residual| * k / 2^16 to nearest, halves away from zero
    assign step_round = {1'b0, prod[32:0]} + 34'd32768;
    assign step       = step_round[33:16];
    assign mean_wide  = {{3{mean_reg[DIST_W-1]}}, mean_reg};
    assign mean_sat_in = neg_reg ? mean_wide - $signed({1'b0, step})
                                 : mean_wide + $signed({1'b0, step});

    always_comb
    begin
        if (mean_sat_in > 19'sd32767)
        begin
            mean_new = 16'h7FFF;
        end
        else if (mean_sat_in < -19'sd32768)
        begin
            mean_new = 16'h8000;
        end
        else
        begin
            mean_new = mean_sat_in[DIST_W-1:0];
        end
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(dabs_reg);
                mul_b  = MUL_B_W'(dabs_reg);
            end
            S_MK:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(mag_reg);
                mul_b  = k_reg;
            end
            S_VK:
            begin
                mul_en = 1'b1;
                mul_a  = var_reg;
                mul_b  = GAIN_ONE - k_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dreq = '0;
        unique case (state_reg)
            S_R:
            begin
                // R = d^2 * 256 / (128 + w)
                dreq.start    = !op_reg;
                dreq.rem_init = REM_W'(prod[30:24]);
                dreq.num      = {prod[23:0], 8'd0};
                dreq.den      = REM_W'({1'b0, wt_reg} + 10'd128);
                dreq.steps    = MEAS_STEPS;
            end
            S_RDIV:
            begin
                // k = P * 65536 / (P + R)
                dreq.start    = dstat.done && (var_reg != VAR_UNKNOWN)
                                && (gain_sum != '0);
                dreq.rem_init = REM_W'(var_reg[VAR_W-1:1]);
                dreq.num      = {var_reg[0], 31'd0};
                dreq.den      = gain_sum;
                dreq.steps    = GAIN_STEPS;
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    sdvf_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sdvf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .stat  (dstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mean_reg     <= '0;
            var_reg      <= VAR_UNKNOWN;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_R;
                end
                S_R:
                begin
                    if (op_reg)
                    begin
                        mean_reg  <= dist_reg;
                        var_reg   <= prod[VAR_W-1:0];
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_RDIV;
                    end
                end
                S_RDIV:
                begin
                    if (dstat.done)
                    begin
                        if (var_reg == VAR_UNKNOWN)
                        begin
                            // first fuse: take the measurement as it is
                            mean_reg  <= dist_reg;
                            var_reg   <= dstat.quo;
                            state_reg <= S_DONE;
                        end
                        else if (gain_sum == '0)
                        begin
                            state_reg <= S_MK;
                        end
                        else
                        begin
                            state_reg <= S_KDIV;
                        end
                    end
                end
                S_KDIV:
                begin
                    if (dstat.done)
                    begin
                        state_reg <= S_MK;
                    end
                end
                S_MK:
                begin
                    state_reg <= S_VK;
                end
                S_VK:
                begin
                    mean_reg  <= mean_new;
                    state_reg <= S_VW;
                end
                S_VW:
                begin
                    var_reg   <= prod[VAR_W+15:16];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= s_tuser;
            dist_reg <= in_dist;
            wt_reg   <= s_tdata[DIST_W+WEIGHT_W-1:DIST_W];
            dabs_reg <= in_dabs;
            neg_reg  <= in_res[DIST_W];
            mag_reg  <= in_res[DIST_W] ? in_res_neg[DIST_W-1:0] : in_res[DIST_W-1:0];
        end
        if (state_reg == S_RDIV && dstat.done)
        begin
            k_reg <= GAIN_ONE;
        end
        else if (state_reg == S_KDIV && dstat.done)
        begin
            k_reg <= dstat.quo[GAIN_W-1:0];
        end
        if (state_reg == S_DONE && out_free)
        begin
            m_tdata_reg <= {7'd0, 1'b1, var_reg, mean_reg};
        end
    end

endmodule
`default_nettype wire

[sv/sdvf_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdvf_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller preloads
// the upper dividend bits as the starting remainder and the remaining bits
// MSB-first in num; once 'steps' quotient bits are in, the quotient sits in the low bits.
// ----------------------------------------------------------------------------
module sdvf_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  sdvf_pkg::div_req_t   req,
    output sdvf_pkg::div_stat_t  stat
);
    import sdvf_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [VAR_W-1:0]  lo_reg, lo_next;
    logic [REM_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb
    begin
        shifted  = {rem_reg, lo_reg[VAR_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        lo_next  = {lo_reg[VAR_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != STEP_W'(1));
            done_reg <= (cnt_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            lo_reg  <= req.num;
            den_reg <= req.den;
            cnt_reg <= req.steps;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = lo_reg;

endmodule
`default_nettype wire

[sv/sdvf_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdvf_mul
// Shared unsigned 32 x 17 multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdvf_mul (
    input  wire                                clk,
    input  wire                                en,
    input  wire [sdvf_pkg::MUL_A_W-1:0]        a,
    input  wire [sdvf_pkg::MUL_B_W-1:0]        b,
    output logic [sdvf_pkg::PROD_W-1:0]        prod
);
    import sdvf_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire
